### rtl/tsms_pkg.sv
// ----------------------------------------------------------------------------
// tsms_pkg
// Shared types and constants for the trackball scroll and motion step block.
// ----------------------------------------------------------------------------
package tsms_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_ENABLE  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_DIVISOR = 8'd1;

  // Sensor status decoding.
  localparam int unsigned  STAT_MOTION_BIT = 7;
  localparam logic [7:0]   STAT_FAULT      = 8'hFF;

  // Scroll divisor handling.
  localparam logic [7:0]   DIV_RESET   = 8'd6;
  localparam logic [7:0]   DIV_DEFAULT = 8'd20;

  // Idle counter and poll interval.
  localparam logic [6:0]   IDLE_CAP     = 7'd100;
  localparam logic [6:0]   IDLE_SLOW_TH = 7'd20;
  localparam logic [4:0]   POLL_SLOW    = 5'd25;
  localparam logic [4:0]   POLL_FAST    = 5'd8;

  // Serial divider geometry: a 9-bit accumulator magnitude over an
  // 8-bit divisor, one quotient bit per cycle.
  localparam int unsigned  QUO_W   = 9;
  localparam int unsigned  REM_W   = 8;
  localparam int unsigned  CNT_W   = 4;
  localparam logic [CNT_W-1:0] DIV_STEPS = 4'd9;

  // Largest step count that can be reported.
  localparam logic [QUO_W-1:0] STEP_MAX = 9'd128;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
    logic [REM_W-1:0] remainder;
  } div_res_t;

endpackage

### rtl/trackball_scroll_motion_step_core.sv
// ----------------------------------------------------------------------------
// trackball_scroll_motion_step_core
// Sequence: an accepted request is decoded and accumulated, then in scroll
// mode with motion both serial dividers run and flag completion with the
// last quotient bit; the result is then loaded into the output register.
// Requests: a new request is taken only after the previous one has been
// loaded, so a result stall holds it off; a new request is taken while the
// previous result still waits in the output register.
// Reset: synchronous, active high; cursor mode, divisor 6, accumulators and
// idle counter cleared.
// ----------------------------------------------------------------------------
module trackball_scroll_motion_step_core (
  input  logic                             clk,
  input  logic                             rst,

  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tsms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,

  // Poll request channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       status_byte,
  input  logic signed [7:0]                raw_x,
  input  logic signed [7:0]                raw_y,

  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             motion_seen,
  output logic                             wheel_valid,
  output logic signed [8:0]                wheel_count,
  output logic                             hwheel_valid,
  output logic signed [8:0]                hwheel_count,
  output logic                             cursor_valid,
  output logic signed [7:0]                cursor_dx,
  output logic signed [7:0]                cursor_dy,
  output logic [4:0]                       poll_interval_ms
);

  // Control sequence: wait for a request, decode and accumulate, in scroll mode
  // with motion run both dividers side by side, then build the result register.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Configuration.
  logic       scroll_enable;
  logic [7:0] scroll_divisor;

  // Architectural state.
  logic signed [9:0] vacc;
  logic signed [9:0] hacc;
  logic [6:0]        idle_polls;

  // Captured request and per-request flags.
  logic [7:0]        stat_q;
  logic signed [7:0] rx_q;
  logic signed [7:0] ry_q;
  logic              seen_q;
  logic              scroll_q;
  logic              vneg;
  logic              hneg;

  // Decode of the captured request.
  logic signed [7:0] dx;
  logic signed [7:0] dy;
  logic [7:0]        ax;
  logic [7:0]        ay;
  logic              motion;
  logic              lock_v;
  logic              lock_h;
  logic              add_v;
  logic              add_h;
  logic signed [9:0] vsum;
  logic signed [9:0] hsum;
  logic [9:0]        vabs;
  logic [9:0]        habs;
  logic [7:0]        div_eff;
  logic              div_start;
  logic              out_free;
  logic              out_load;
  logic              cfg_write;

  tsms_pkg::div_res_t vres;
  tsms_pkg::div_res_t hres;

  // Result assembly.
  logic [8:0]        vq_clamp;
  logic [8:0]        hq_clamp;
  logic signed [9:0] vrem;
  logic signed [9:0] hrem;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = (state != S_IDLE);

  // The rotation puts the wrapped negative of Y on the X axis, so a Y count
  // of -128 stays -128. X becomes the vertical axis unchanged.
  assign dx = 8'(-ry_q);
  assign dy = rx_q;
  assign ax = dx[7] ? 8'(-dx) : dx;
  assign ay = dy[7] ? 8'(-dy) : dy;

  assign motion = stat_q[tsms_pkg::STAT_MOTION_BIT] && (stat_q != tsms_pkg::STAT_FAULT) &&
                  ((dx != 8'sd0) || (dy != 8'sd0));

  // Axis lock: a strongly vertical or strongly horizontal move feeds only its
  // own accumulator; a diagonal move feeds both.
  assign lock_v = ({1'b0, ay} >= {ax, 1'b0});
  assign lock_h = !lock_v && ({1'b0, ax} >= {ay, 1'b0});
  assign add_v  = !lock_h;
  assign add_h  = !lock_v;

  assign vsum = vacc + (add_v ? {{2{dy[7]}}, dy} : 10'sd0);
  assign hsum = hacc + (add_h ? {{2{dx[7]}}, dx} : 10'sd0);
  assign vabs = vsum[9] ? 10'(-vsum) : vsum;
  assign habs = hsum[9] ? 10'(-hsum) : hsum;

  assign div_eff   = (scroll_divisor == 8'd0) ? tsms_pkg::DIV_DEFAULT : scroll_divisor;
  assign div_start = (state == S_ADD) && motion && scroll_enable;

  // Both accumulators are divided whenever a divide runs. A magnitude below the divisor gives
  // a zero quotient and leaves the value as its own remainder, so no separate
  // threshold compare is needed.
  tsms_div u_vdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (vabs[tsms_pkg::QUO_W-1:0]),
    .divisor  (div_eff),
    .res      (vres)
  );

  tsms_div u_hdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (habs[tsms_pkg::QUO_W-1:0]),
    .divisor  (div_eff),
    .res      (hres)
  );

  // Step counts saturate at 128 while the accumulators keep the remainder.
  assign vq_clamp = (vres.quotient > tsms_pkg::STEP_MAX) ? tsms_pkg::STEP_MAX : vres.quotient;
  assign hq_clamp = (hres.quotient > tsms_pkg::STEP_MAX) ? tsms_pkg::STEP_MAX : hres.quotient;
  assign vrem     = vneg ? 10'(-{2'b00, vres.remainder}) : {2'b00, vres.remainder};
  assign hrem     = hneg ? 10'(-{2'b00, hres.remainder}) : {2'b00, hres.remainder};

  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_OUT) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        if (div_start) begin
          state_next = S_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (vres.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      scroll_enable  <= 1'b0;
      scroll_divisor <= tsms_pkg::DIV_RESET;
      vacc           <= '0;
      hacc           <= '0;
      idle_polls     <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        // Any write of the mode register drops partial scroll motion.
        if (cfg_index == tsms_pkg::REG_SCROLL_ENABLE) begin
          scroll_enable <= cfg_data[0];
          vacc          <= '0;
          hacc          <= '0;
        end else if (cfg_index == tsms_pkg::REG_SCROLL_DIVISOR) begin
          scroll_divisor <= cfg_data;
        end
      end else if (out_load && seen_q && scroll_q) begin
        vacc <= vrem;
        hacc <= hrem;
      end

      if (state == S_ADD) begin
        if (motion) begin
          idle_polls <= '0;
        end else if (idle_polls < tsms_pkg::IDLE_CAP) begin
          idle_polls <= idle_polls + 7'd1;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and result payload carry no reset.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      stat_q <= status_byte;
      rx_q   <= raw_x;
      ry_q   <= raw_y;
    end

    if (state == S_ADD) begin
      seen_q   <= motion;
      scroll_q <= scroll_enable;
      vneg     <= vsum[9];
      hneg     <= hsum[9];
    end

    if (out_load) begin
      motion_seen      <= seen_q;
      wheel_valid      <= 1'b0;
      wheel_count      <= '0;
      hwheel_valid     <= 1'b0;
      hwheel_count     <= '0;
      cursor_valid     <= 1'b0;
      cursor_dx        <= '0;
      cursor_dy        <= '0;
      poll_interval_ms <= (idle_polls >= tsms_pkg::IDLE_SLOW_TH) ?
                          tsms_pkg::POLL_SLOW : tsms_pkg::POLL_FAST;
      if (seen_q && scroll_q) begin
        // The wheel reports the negated vertical quotient.
        wheel_valid  <= (vres.quotient != '0);
        wheel_count  <= vneg ? $signed(vq_clamp) : $signed(9'(-vq_clamp));
        hwheel_valid <= (hres.quotient != '0);
        hwheel_count <= hneg ? $signed(9'(-hq_clamp)) : $signed(hq_clamp);
      end else if (seen_q) begin
        cursor_valid <= 1'b1;
        cursor_dx    <= dx;
        cursor_dy    <= dy;
      end
    end
  end

`ifndef SYNTHESIS
  // A remainder is always below the largest divisor, so a stored
  // accumulator never reaches 255 in magnitude.
  a_acc_bounded: assert property (@(posedge clk) disable iff (rst)
    (vacc < 10'sd255) && (vacc > -10'sd255) && (hacc < 10'sd255) && (hacc > -10'sd255))
    else $error("scroll accumulator out of remainder range");

  // Both dividers are started together and must finish together.
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    vres.done == hres.done)
    else $error("dividers out of step");

  // The idle counter saturates at its cap.
  a_idle_cap: assert property (@(posedge clk) disable iff (rst)
    idle_polls <= tsms_pkg::IDLE_CAP)
    else $error("idle counter passed its cap");

  // A divide result is only consumed in the state that waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    vres.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");
`endif

endmodule

### rtl/tsms_div.sv
// ----------------------------------------------------------------------------
// tsms_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsms_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tsms_pkg::QUO_W-1:0]  dividend,
  input  logic [7:0]                  divisor,
  output tsms_pkg::div_res_t          res
);

  logic [tsms_pkg::CNT_W-1:0] cnt;
  logic                       done;
  logic [tsms_pkg::QUO_W-1:0] quo;
  logic [tsms_pkg::REM_W-1:0] rem;
  logic [7:0]                 dvs;
  logic [tsms_pkg::REM_W:0]   trial;
  logic [tsms_pkg::REM_W:0]   diff;
  logic                       fits;

  // The dividend bits shift out of the top of quo while quotient bits
  // enter at the bottom.
  assign trial = {rem, quo[tsms_pkg::QUO_W-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= tsms_pkg::DIV_STEPS;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == 4'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= diff[tsms_pkg::REM_W-1:0];
        quo <= {quo[tsms_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem <= trial[tsms_pkg::REM_W-1:0];
        quo <= {quo[tsms_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule
